FILE: rtl/cfc_pkg.sv
package cfc_pkg;

   localparam int HDR_FIXED = 12;
   localparam int MAGIC_LEN = 4;

   // Byte offsets of the fixed header fields.
   localparam int OFS_VERSION   = 4;
   localparam int OFS_TYPE      = 5;
   localparam int OFS_BUCKET_HI = 6;
   localparam int OFS_BUCKET_LO = 7;
   localparam int OFS_KEY_HI    = 8;
   localparam int OFS_KEY_LO    = 9;
   localparam int OFS_MANIF_HI  = 10;
   localparam int OFS_MANIF_LO  = 11;

   localparam logic [7:0] MAGIC_WORD [MAGIC_LEN] = '{8'h4D, 8'h33, 8'h4E, 8'h53};

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT_VERSION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUT_CODE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOMBSTONE_CODE = 2'd2;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic        frame_valid;
      logic        is_tombstone;
      logic [15:0] bucket_length;
      logic [15:0] key_length;
      logic [15:0] manifest_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0] format_version;
      logic [7:0] put_code;
      logic [7:0] tombstone_code;
   } cfg_type;

endpackage

FILE: rtl/cfc_in_stage.sv
module cfc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cfc_pkg::req_type req_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cfc_pkg::req_type out_data
);

   logic             valid_ff;
   logic             valid_in;
   cfc_pkg::req_type data_ff;

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

FILE: rtl/cfc_parser.sv
module cfc_parser #(
   parameter int TENANT_BYTES    = 16,
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  cfc_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  cfc_pkg::req_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfc_pkg::rsp_type rsp_data
);

   localparam int HDR_TOTAL = cfc_pkg::HDR_FIXED + TENANT_BYTES;
   localparam int POS_CAP   = MAX_FRAME_BYTES + 1;
   localparam int POS_W     = $clog2(POS_CAP + 1);
   localparam int SUM_W     = $clog2(HDR_TOTAL + 3 * 65535 + 1);

   logic [POS_W-1:0] pos_ff, pos_in, pos_upd;
   logic             hdr_bad_ff, hdr_bad_in, hdr_bad_upd;
   logic [7:0]       type_ff, type_in, type_upd;
   logic [15:0]      bucket_ff, bucket_in, bucket_upd;
   logic [15:0]      key_ff, key_in, key_upd;
   logic [15:0]      manif_ff, manif_in, manif_upd;

   logic             rsp_valid_ff, rsp_valid_in;
   cfc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             take;
   logic             last;
   logic [7:0]       b;
   logic [SUM_W-1:0] size;
   logic [SUM_W-1:0] expect_len;
   logic             is_put, is_tomb, ok;

   assign b    = in_data.frame_byte;
   assign last = in_data.frame_end;
   // A non-final byte produces no result, so it never waits on the output side.
   assign take     = in_valid && (!last || !rsp_valid_ff || rsp_ready);
   assign in_ready = take;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      hdr_bad_upd = hdr_bad_ff;
      type_upd    = type_ff;
      bucket_upd  = bucket_ff;
      key_upd     = key_ff;
      manif_upd   = manif_ff;

      if (pos_ff < POS_W'(cfc_pkg::MAGIC_LEN)) begin
         if (b != cfc_pkg::MAGIC_WORD[pos_ff[1:0]]) begin
            hdr_bad_upd = 1'b1;
         end
      end

      unique case (pos_ff)
         POS_W'(cfc_pkg::OFS_VERSION): begin
            if (b != cfg.format_version) begin
               hdr_bad_upd = 1'b1;
            end
         end
         POS_W'(cfc_pkg::OFS_TYPE):      type_upd         = b;
         POS_W'(cfc_pkg::OFS_BUCKET_HI): bucket_upd[15:8] = b;
         POS_W'(cfc_pkg::OFS_BUCKET_LO): bucket_upd[7:0]  = b;
         POS_W'(cfc_pkg::OFS_KEY_HI):    key_upd[15:8]    = b;
         POS_W'(cfc_pkg::OFS_KEY_LO):    key_upd[7:0]     = b;
         POS_W'(cfc_pkg::OFS_MANIF_HI):  manif_upd[15:8]  = b;
         POS_W'(cfc_pkg::OFS_MANIF_LO):  manif_upd[7:0]   = b;
         default: begin
         end
      endcase

      if (pos_ff != POS_W'(POS_CAP)) begin
         pos_upd = pos_ff + POS_W'(1);
      end else begin
         pos_upd = pos_ff;
      end
   end

   always_comb begin
      size       = SUM_W'(pos_upd);
      expect_len = SUM_W'(HDR_TOTAL) + SUM_W'(bucket_upd) + SUM_W'(key_upd)
                   + SUM_W'(manif_upd);
      is_put     = (type_upd == cfg.put_code);
      is_tomb    = !is_put && (type_upd == cfg.tombstone_code);
      ok = !hdr_bad_upd
           && size >= SUM_W'(HDR_TOTAL)
           && size <= SUM_W'(MAX_FRAME_BYTES)
           && (is_put || is_tomb)
           && !(is_put && manif_upd == 16'd0)
           && !(is_tomb && manif_upd != 16'd0)
           && bucket_upd != 16'd0
           && key_upd != 16'd0
           && expect_len == size;

      rsp_data_in.frame_valid     = ok;
      rsp_data_in.is_tombstone    = ok && is_tomb;
      rsp_data_in.bucket_length   = ok ? bucket_upd : 16'd0;
      rsp_data_in.key_length      = ok ? key_upd : 16'd0;
      rsp_data_in.manifest_length = ok ? manif_upd : 16'd0;

      // The final byte clears the frame state for the next frame.
      if (take && last) begin
         pos_in     = '0;
         hdr_bad_in = 1'b0;
         type_in    = 8'd0;
         bucket_in  = 16'd0;
         key_in     = 16'd0;
         manif_in   = 16'd0;
      end else if (take) begin
         pos_in     = pos_upd;
         hdr_bad_in = hdr_bad_upd;
         type_in    = type_upd;
         bucket_in  = bucket_upd;
         key_in     = key_upd;
         manif_in   = manif_upd;
      end else begin
         pos_in     = pos_ff;
         hdr_bad_in = hdr_bad_ff;
         type_in    = type_ff;
         bucket_in  = bucket_ff;
         key_in     = key_ff;
         manif_in   = manif_ff;
      end

      if (take && last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_bad_ff   <= 1'b0;
         type_ff      <= 8'd0;
         bucket_ff    <= 16'd0;
         key_ff       <= 16'd0;
         manif_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hdr_bad_ff   <= hdr_bad_in;
         type_ff      <= type_in;
         bucket_ff    <= bucket_in;
         key_ff       <= key_in;
         manif_ff     <= manif_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      take && last |=> rsp_valid_ff)
      else $error("final byte did not produce a result");

   a_last_clears_pos: assert property (@(posedge clock) disable iff (reset)
      take && last |=> pos_ff == '0)
      else $error("byte count not cleared after final byte");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(POS_CAP))
      else $error("byte count beyond saturation value");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.frame_valid |->
         !rsp_data_ff.is_tombstone && rsp_data_ff.bucket_length == 16'd0
         && rsp_data_ff.key_length == 16'd0 && rsp_data_ff.manifest_length == 16'd0)
      else $error("rejected frame carries nonzero fields");

   a_valid_lengths: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_valid |->
         rsp_data_ff.bucket_length != 16'd0 && rsp_data_ff.key_length != 16'd0)
      else $error("accepted frame with zero bucket or key length");
`endif

endmodule

FILE: rtl/command_frame_checker_top.sv
// Command frame checker. Bytes of a frame arrive one per transaction on the
// req_ channel, with frame_end high on the final byte; one result transaction
// appears on the rsp_ channel for each frame, and none for other bytes. A new
// byte is taken every cycle at full rate, since the frame state update and all
// header checks sit in one pass between the input register and the result
// register; the result register is loaded as the final byte leaves the input
// register. Only a final byte that finds the result register still full waits,
// and the bytes behind it wait with it. The three csr_ registers (format
// version, put code, tombstone code) are always ready and should be written
// only while no frame is in progress.
module command_frame_checker_top #(
   parameter int TENANT_BYTES    = 16,
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cfc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cfc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_data
);

   cfc_pkg::cfg_type cfg_ff, cfg_in;
   logic             stg_valid;
   logic             stg_ready;
   cfc_pkg::req_type stg_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cfc_pkg::CSR_FORMAT_VERSION: cfg_in.format_version = csr_data;
            cfc_pkg::CSR_PUT_CODE:       cfg_in.put_code       = csr_data;
            cfc_pkg::CSR_TOMBSTONE_CODE: cfg_in.tombstone_code = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_version <= 8'd1;
         cfg_ff.put_code       <= 8'd1;
         cfg_ff.tombstone_code <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (stg_valid),
      .out_ready (stg_ready),
      .out_data  (stg_data)
   );

   cfc_parser #(
      .TENANT_BYTES    (TENANT_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (stg_valid),
      .in_ready  (stg_ready),
      .in_data   (stg_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
